// File: design/i2crw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crw_pkg
// Shared types, codes and plan table for the I2C register access master.
// ----------------------------------------------------------------------------
package i2crw_pkg;

  // request codes carried on req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // bus phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_SEND  = 3'd2;
  localparam logic [2:0] PH_RECV  = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam logic [9:0]  STEP_TICKS_RESET = 10'd10;

  // decoupling queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one classified tick as it travels through the queue
  typedef struct packed {
    logic       start;
    logic       rd;
    logic [7:0] device;
    logic [7:0] reg_byte;
    logic [7:0] data;
    logic       sda_in;
  } entry_t;

  // phase of each segment of a transaction
  function automatic logic [2:0] plan_phase(input logic rd, input logic [2:0] seg);
    logic [2:0] ph;
    ph = PH_IDLE;
    if (rd) begin
      case (seg)
        3'd0:    ph = PH_START;
        3'd1:    ph = PH_SEND;
        3'd2:    ph = PH_SEND;
        3'd3:    ph = PH_START;
        3'd4:    ph = PH_SEND;
        3'd5:    ph = PH_RECV;
        3'd6:    ph = PH_STOP;
        default: ph = PH_IDLE;
      endcase
    end else begin
      case (seg)
        3'd0:    ph = PH_START;
        3'd1:    ph = PH_SEND;
        3'd2:    ph = PH_SEND;
        3'd3:    ph = PH_SEND;
        3'd4:    ph = PH_STOP;
        default: ph = PH_IDLE;
      endcase
    end
    return ph;
  endfunction

endpackage

// File: design/i2crw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crw_front
// Accepts input beats, classifies the request and queues them for the engine.
// ----------------------------------------------------------------------------
module i2crw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [7:0]          device_addr,
  input  logic [7:0]          reg_addr,
  input  logic [7:0]          write_data,
  input  logic                sda_in,
  output logic                q_valid,
  output i2crw_pkg::entry_t   q_entry,
  input  logic                q_pop
);

  i2crw_pkg::entry_t                    mem [i2crw_pkg::QDEPTH];
  logic [i2crw_pkg::QPTR_W-1:0]         wr_ptr;
  logic [i2crw_pkg::QPTR_W-1:0]         rd_ptr;
  logic [i2crw_pkg::QCNT_W-1:0]         count;
  logic                                 push;
  i2crw_pkg::entry_t                    new_entry;

  // classify the request
  always_comb begin
    new_entry.start    = (req_type == i2crw_pkg::REQ_WRITE) ||
                         (req_type == i2crw_pkg::REQ_READ);
    new_entry.rd       = (req_type == i2crw_pkg::REQ_READ);
    new_entry.device   = device_addr;
    new_entry.reg_byte = reg_addr;
    new_entry.data     = write_data;
    new_entry.sda_in   = sda_in;
  end

  assign in_stall = (count == i2crw_pkg::QCNT_W'(i2crw_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_entry  = mem[rd_ptr];

  // store beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == i2crw_pkg::QPTR_W'(i2crw_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == i2crw_pkg::QPTR_W'(i2crw_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= i2crw_pkg::QCNT_W'(i2crw_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != '0))
    else $error("pop from empty queue");

endmodule

// File: design/i2crw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crw_engine
// Bus sequencer: runs one tick per queued beat and registers the pin levels.
// ----------------------------------------------------------------------------
module i2crw_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic [9:0]          step_ticks,
  input  logic                q_valid,
  input  i2crw_pkg::entry_t   q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                scl_level,
  output logic                sda_level,
  output logic                sda_drive,
  output logic                busy_res,
  output logic                done_res,
  output logic [7:0]          read_data
);

  // sequencer state
  logic [2:0] phase;
  logic [2:0] step_in_phase;
  logic [3:0] bit_index;
  logic [2:0] byte_index;
  logic [9:0] tick_count;
  logic       is_read;
  logic [7:0] saved_device;
  logic [7:0] saved_register;
  logic [7:0] saved_data;
  logic [7:0] receive_shift;
  logic [7:0] held_read;

  logic [2:0] phase_next;
  logic [2:0] step_in_phase_next;
  logic [3:0] bit_index_next;
  logic [2:0] byte_index_next;
  logic [9:0] tick_count_next;
  logic       is_read_next;
  logic [7:0] saved_device_next;
  logic [7:0] saved_register_next;
  logic [7:0] saved_data_next;
  logic [7:0] receive_shift_next;
  logic [7:0] held_read_next;

  logic scl_next;
  logic sda_next;
  logic drv_next;
  logic busy_next;
  logic done_next;

  // take a beat when the output register is free or being emptied
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // one bus tick
  always_comb begin
    logic [2:0]  e_phase;
    logic [2:0]  e_sip;
    logic [3:0]  e_bit;
    logic [2:0]  e_byte;
    logic [9:0]  e_tick;
    logic        e_rd;
    logic [7:0]  e_dev;
    logic [7:0]  e_reg;
    logic [7:0]  e_data;
    logic [7:0]  e_shift;
    logic [7:0]  tx_byte;
    logic [9:0]  hold;
    logic        last_tick;
    logic [2:0]  sip_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_new;
    logic        seg_adv;

    // start a transaction on an idle tick
    if (phase == i2crw_pkg::PH_IDLE && q_entry.start) begin
      e_phase = i2crw_pkg::PH_START;
      e_sip   = '0;
      e_bit   = '0;
      e_byte  = '0;
      e_tick  = '0;
      e_rd    = q_entry.rd;
      e_dev   = q_entry.device;
      e_reg   = q_entry.reg_byte;
      e_data  = q_entry.data;
      e_shift = '0;
    end else begin
      e_phase = phase;
      e_sip   = step_in_phase;
      e_bit   = bit_index;
      e_byte  = byte_index;
      e_tick  = tick_count;
      e_rd    = is_read;
      e_dev   = saved_device;
      e_reg   = saved_register;
      e_data  = saved_data;
      e_shift = receive_shift;
    end

    case (e_byte)
      3'd1:    tx_byte = e_dev;
      3'd2:    tx_byte = e_reg;
      default: tx_byte = e_rd ? (e_dev + 8'd1) : e_data;
    endcase

    hold      = (step_ticks == '0) ? 10'd1 : step_ticks;
    last_tick = ({1'b0, e_tick} + 11'd1) >= {1'b0, hold};
    sip_inc   = e_sip + 3'd1;
    bit_inc   = e_bit + 4'd1;
    shift_new = {e_shift[6:0], q_entry.sda_in};
    seg_adv   = 1'b0;

    phase_next          = e_phase;
    step_in_phase_next  = e_sip;
    bit_index_next      = e_bit;
    byte_index_next     = e_byte;
    tick_count_next     = e_tick;
    is_read_next        = e_rd;
    saved_device_next   = e_dev;
    saved_register_next = e_reg;
    saved_data_next     = e_data;
    receive_shift_next  = e_shift;
    held_read_next      = held_read;

    scl_next  = 1'b1;
    sda_next  = 1'b1;
    drv_next  = 1'b0;
    busy_next = 1'b0;
    done_next = 1'b0;

    if (e_phase != i2crw_pkg::PH_IDLE) begin
      // drive pins for this step
      busy_next = 1'b1;
      scl_next  = (e_sip != 3'd0);
      case (e_phase)
        i2crw_pkg::PH_START: begin
          sda_next = (e_sip != 3'd2);
          drv_next = 1'b1;
        end
        i2crw_pkg::PH_SEND: begin
          if (e_bit < 4'(i2crw_pkg::BITS_PER_BYTE)) begin
            sda_next = tx_byte[3'd7 - e_bit[2:0]];
            drv_next = 1'b1;
          end
        end
        i2crw_pkg::PH_STOP: begin
          sda_next = (e_sip == 3'd2);
          drv_next = 1'b1;
        end
        default: begin
          sda_next = 1'b1;
          drv_next = 1'b0;
        end
      endcase

      // advance the step timer and the step sequence
      if (!last_tick) begin
        tick_count_next = e_tick + 10'd1;
      end else begin
        tick_count_next    = '0;
        step_in_phase_next = sip_inc;
        case (e_phase)
          i2crw_pkg::PH_START: begin
            if (sip_inc >= 3'd3) seg_adv = 1'b1;
          end
          i2crw_pkg::PH_SEND: begin
            if (sip_inc >= 3'd2) begin
              step_in_phase_next = '0;
              bit_index_next     = bit_inc;
              if (bit_inc > 4'(i2crw_pkg::BITS_PER_BYTE)) seg_adv = 1'b1;
            end
          end
          i2crw_pkg::PH_RECV: begin
            if (sip_inc >= 3'd2) begin
              step_in_phase_next = '0;
              receive_shift_next = shift_new;
              bit_index_next     = bit_inc;
              if (bit_inc >= 4'(i2crw_pkg::BITS_PER_BYTE)) begin
                held_read_next = shift_new;
                seg_adv        = 1'b1;
              end
            end
          end
          default: begin
            if (sip_inc >= 3'd3) begin
              done_next          = 1'b1;
              phase_next         = i2crw_pkg::PH_IDLE;
              step_in_phase_next = '0;
              bit_index_next     = '0;
              byte_index_next    = '0;
            end
          end
        endcase
        // move to the next segment of the plan
        if (seg_adv) begin
          byte_index_next    = e_byte + 3'd1;
          phase_next         = i2crw_pkg::plan_phase(e_rd, e_byte + 3'd1);
          step_in_phase_next = '0;
          bit_index_next     = '0;
        end
      end
    end
  end

  // update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2crw_pkg::PH_IDLE;
      step_in_phase <= '0;
      bit_index     <= '0;
      byte_index    <= '0;
      tick_count    <= '0;
      is_read       <= 1'b0;
      held_read     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        step_in_phase <= step_in_phase_next;
        bit_index     <= bit_index_next;
        byte_index    <= byte_index_next;
        tick_count    <= tick_count_next;
        is_read       <= is_read_next;
        held_read     <= held_read_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // update payload and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      saved_data     <= saved_data_next;
      receive_shift  <= receive_shift_next;
      scl_level      <= scl_next;
      sda_level      <= sda_next;
      sda_drive      <= drv_next;
      busy_res       <= busy_next;
      done_res       <= done_next;
    end
  end

  assign read_data = held_read;

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == i2crw_pkg::PH_IDLE) |->
      (tick_count == '0 && step_in_phase == '0 && bit_index == '0 && byte_index == '0))
    else $error("idle with stale sequencer state");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (busy_res && scl_level && sda_level && sda_drive))
    else $error("done beat without stop step");

  a_two_step_bits: assert property (@(posedge clk) disable iff (rst)
    (phase == i2crw_pkg::PH_SEND || phase == i2crw_pkg::PH_RECV) |->
      (step_in_phase < 3'd2 && bit_index <= 4'(i2crw_pkg::BITS_PER_BYTE)))
    else $error("bit step out of range");

endmodule

// File: design/i2c_register_access_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master_top
// I2C master issuing register writes and reads, one input beat per bus tick.
// ----------------------------------------------------------------------------
// Every input beat is one tick of the bus engine and yields exactly one
// result beat carrying the pin levels for that tick. A beat is classified
// and placed in a two-entry queue, then the sequencer runs the tick
// combinationally and registers the result in the output register. One
// beat per cycle is sustained while neither side stalls; the sequencer
// state update is the loop that sets that rate. Either side may stall
// without blocking the other until the queue fills.
// step_ticks (address 0) sets how many ticks each pin step is held.
module i2c_register_access_master_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  device_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_STEP_TICKS = 1'b0;

  logic [9:0]          step_ticks;
  logic                q_valid;
  logic                q_pop;
  i2crw_pkg::entry_t   q_entry;
  logic                cfg_write;

  // register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_STEP_TICKS);
  assign prdata    = (paddr[2] == REG_STEP_TICKS) ? {22'd0, step_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks <= i2crw_pkg::STEP_TICKS_RESET;
    end else if (cfg_write) begin
      step_ticks <= pwdata[9:0];
    end
  end

  i2crw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .device_addr (device_addr),
    .reg_addr    (reg_addr),
    .write_data  (write_data),
    .sda_in      (sda_in),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  i2crw_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step_ticks (step_ticks),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_data  (read_data)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C register access master.
// ----------------------------------------------------------------------------
// Each input beat is one bus tick and yields one result beat with the pin
// levels of that tick. A cycle-accurate bus predictor runs on every accepted
// input beat and queues the expected pins. The checker compares each result
// beat with the oldest entry. Directed tests cover idle ticks, byte
// extremes, reads with device wrap, requests while busy, the unused request
// code and step lengths 0, 1, 10 and 1023, the long ones cut short by a step
// change part way through a transaction. Random traffic then runs under
// several step lengths with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] REQ_SPARE      = 2'd3;
  localparam logic [2:0] REG_STEP_TICKS = 3'd0;
  localparam int         SDA_LOW        = 0;
  localparam int         SDA_HIGH       = 1;
  localparam int         SDA_RAND       = 2;
  localparam int         HOLD_LEN       = 64;
  localparam int         WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
  } pins_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = i2crw_pkg::REQ_TICK;
  logic [7:0]  device_addr = 8'd0;
  logic [7:0]  reg_addr = 8'd0;
  logic [7:0]  write_data = 8'd0;
  logic        sda_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = REG_STEP_TICKS;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predicted bus engine state
  logic [9:0] step_cfg = i2crw_pkg::STEP_TICKS_RESET;
  logic [2:0] bus_phase = i2crw_pkg::PH_IDLE;
  logic [2:0] bus_step = 3'd0;
  logic [3:0] bus_bit = 4'd0;
  logic [2:0] bus_seg = 3'd0;
  logic [9:0] bus_ticks = 10'd0;
  logic       bus_rd = 1'b0;
  logic [7:0] bus_dev = 8'd0;
  logic [7:0] bus_reg = 8'd0;
  logic [7:0] bus_dat = 8'd0;
  logic [7:0] bus_shift = 8'd0;
  logic [7:0] bus_rdata = 8'd0;

  pins_t pins_due[$];

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_on = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int n_err = 0;
  int n_beats = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_done = 0;

  i2c_register_access_master_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .device_addr(device_addr),
    .reg_addr   (reg_addr),
    .write_data (write_data),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_data  (read_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // move to the next segment of the running transaction
  function automatic void next_seg();
    bus_seg = bus_seg + 3'd1;
    bus_step = 3'd0;
    bus_bit = 4'd0;
    if (bus_rd) begin
      case (bus_seg)
        3'd1, 3'd2, 3'd4: bus_phase = i2crw_pkg::PH_SEND;
        3'd3:             bus_phase = i2crw_pkg::PH_START;
        3'd5:             bus_phase = i2crw_pkg::PH_RECV;
        3'd6:             bus_phase = i2crw_pkg::PH_STOP;
        default:          bus_phase = i2crw_pkg::PH_IDLE;
      endcase
    end else begin
      case (bus_seg)
        3'd1, 3'd2, 3'd3: bus_phase = i2crw_pkg::PH_SEND;
        3'd4:             bus_phase = i2crw_pkg::PH_STOP;
        default:          bus_phase = i2crw_pkg::PH_IDLE;
      endcase
    end
  endfunction

  // advance the bus engine by one tick and queue the pins it shows
  function automatic void bus_tick(logic [1:0] req, logic [7:0] dev, logic [7:0] rg,
                                   logic [7:0] dat, logic sin);
    pins_t p;
    int    hold;
    logic  [7:0] tx_byte;
    p = '{scl: 1'b1, sda: 1'b1, drv: 1'b0, busy: 1'b0, done: 1'b0, rdata: 8'd0};
    hold = (step_cfg == 10'd0) ? 1 : int'(step_cfg);
    if (bus_phase == i2crw_pkg::PH_IDLE &&
        (req == i2crw_pkg::REQ_WRITE || req == i2crw_pkg::REQ_READ)) begin
      bus_rd = (req == i2crw_pkg::REQ_READ);
      bus_dev = dev;
      bus_reg = rg;
      bus_dat = dat;
      bus_shift = 8'd0;
      bus_seg = 3'd0;
      bus_phase = i2crw_pkg::PH_START;
      bus_step = 3'd0;
      bus_bit = 4'd0;
      bus_ticks = 10'd0;
      if (bus_rd) n_reads++;
      else n_writes++;
    end
    if (bus_phase != i2crw_pkg::PH_IDLE) begin
      p.busy = 1'b1;
      p.scl = (bus_step != 3'd0);
      case (bus_phase)
        i2crw_pkg::PH_START: begin
          p.sda = (bus_step != 3'd2);
          p.drv = 1'b1;
        end
        i2crw_pkg::PH_SEND: begin
          if (bus_bit < 4'(i2crw_pkg::BITS_PER_BYTE)) begin
            if (bus_seg == 3'd1) tx_byte = bus_dev;
            else if (bus_seg == 3'd2) tx_byte = bus_reg;
            else if (bus_rd) tx_byte = bus_dev + 8'd1;
            else tx_byte = bus_dat;
            p.sda = tx_byte[3'd7 - bus_bit[2:0]];
            p.drv = 1'b1;
          end
        end
        i2crw_pkg::PH_STOP: begin
          p.sda = (bus_step == 3'd2);
          p.drv = 1'b1;
        end
        default: ;
      endcase
      // hold each pin step for the configured number of ticks
      if (int'(bus_ticks) + 1 < hold) begin
        bus_ticks = bus_ticks + 10'd1;
      end else begin
        bus_ticks = 10'd0;
        bus_step = bus_step + 3'd1;
        case (bus_phase)
          i2crw_pkg::PH_START: begin
            if (bus_step >= 3'd3) next_seg();
          end
          i2crw_pkg::PH_SEND: begin
            if (bus_step >= 3'd2) begin
              bus_step = 3'd0;
              bus_bit = bus_bit + 4'd1;
              if (bus_bit > 4'(i2crw_pkg::BITS_PER_BYTE)) next_seg();
            end
          end
          i2crw_pkg::PH_RECV: begin
            if (bus_step >= 3'd2) begin
              bus_step = 3'd0;
              bus_shift = {bus_shift[6:0], sin};
              bus_bit = bus_bit + 4'd1;
              if (bus_bit >= 4'(i2crw_pkg::BITS_PER_BYTE)) begin
                bus_rdata = bus_shift;
                next_seg();
              end
            end
          end
          default: begin
            if (bus_step >= 3'd3) begin
              p.done = 1'b1;
              bus_phase = i2crw_pkg::PH_IDLE;
              bus_step = 3'd0;
              bus_bit = 4'd0;
              bus_seg = 3'd0;
            end
          end
        endcase
      end
    end
    p.rdata = bus_rdata;
    pins_due.push_back(p);
  endfunction

  // offer one input beat, with random gaps, and hold it until accepted
  task automatic send_beat(logic [1:0] req, logic [7:0] dev, logic [7:0] rg,
                           logic [7:0] dat, logic sin);
    while (tx_gaps && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      req_type <= 2'($urandom_range(3));
      device_addr <= 8'($urandom_range(255));
      reg_addr <= 8'($urandom_range(255));
      write_data <= 8'($urandom_range(255));
      sda_in <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    device_addr <= dev;
    reg_addr <= rg;
    write_data <= dat;
    sda_in <= sin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_tick(req, dev, rg, dat, sin);
    n_beats++;
  endtask

  // tick until the running transaction ends, sprinkling ignored requests
  task automatic finish_transaction(int noise_pct, int sda_sel);
    logic [1:0] req;
    logic       sin;
    while (bus_phase != i2crw_pkg::PH_IDLE) begin
      if (sda_sel == SDA_RAND) sin = 1'($urandom_range(1));
      else sin = (sda_sel == SDA_HIGH);
      if ($urandom_range(99) < noise_pct) begin
        req = 2'($urandom_range(i2crw_pkg::REQ_TICK, REQ_SPARE));
      end else begin
        req = i2crw_pkg::REQ_TICK;
      end
      send_beat(req, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), sin);
    end
  endtask

  // stop offering beats and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write step_ticks once all expected results have drained, then read it back
  task automatic set_step(logic [9:0] v);
    logic [31:0] got;
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_STEP_TICKS;
    pwdata <= {22'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    step_cfg = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[9:0] !== v) begin
      $error("step_ticks readback expected %0d got %0d", v, got[9:0]);
      n_err++;
    end
  endtask

  // idle ticks, then a write at the reset step length, finished at step one
  task automatic test_reset_step();
    repeat (3) send_beat(i2crw_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_beat(i2crw_pkg::REQ_WRITE, 8'hFF, 8'h00, 8'h81, 1'b0);
    repeat (30) send_beat(i2crw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 1'($urandom_range(1)));
    set_step(10'd1);
    finish_transaction(0, SDA_RAND);
  endtask

  // writes with all-zero, all-one and alternating bytes
  task automatic test_write_bytes();
    set_step(10'd1);
    send_beat(i2crw_pkg::REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0);
    finish_transaction(0, SDA_LOW);
    send_beat(i2crw_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    finish_transaction(0, SDA_HIGH);
    send_beat(i2crw_pkg::REQ_WRITE, 8'h5A, 8'hA5, 8'h3C, 1'b0);
    finish_transaction(0, SDA_RAND);
  endtask

  // reads with the device byte wrapping and extreme received bytes
  task automatic test_read_bytes();
    send_beat(i2crw_pkg::REQ_READ, 8'hFF, 8'h80, 8'h00, 1'b1);
    finish_transaction(0, SDA_HIGH);
    send_beat(i2crw_pkg::REQ_READ, 8'h00, 8'h7F, 8'hFF, 1'b0);
    finish_transaction(0, SDA_LOW);
    send_beat(i2crw_pkg::REQ_READ, 8'h7E, 8'h01, 8'h55, 1'b1);
    finish_transaction(0, SDA_RAND);
  endtask

  // random request codes on every tick: ignored while busy, taken on an idle tick
  task automatic test_requests_while_busy();
    repeat (200) begin
      send_beat(2'($urandom_range(i2crw_pkg::REQ_TICK, REQ_SPARE)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    send_beat(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    finish_transaction(100, SDA_RAND);
  endtask

  // zero step length behaves as one tick per step
  task automatic test_step_zero();
    set_step(10'd0);
    send_beat(i2crw_pkg::REQ_READ, 8'hA0, 8'h0F, 8'hF0, 1'b1);
    finish_transaction(20, SDA_RAND);
  endtask

  // longest step length: hold the first step, then finish at step one
  task automatic test_step_max();
    set_step(10'd1023);
    send_beat(i2crw_pkg::REQ_WRITE, 8'hC3, 8'h3C, 8'h96, 1'b0);
    repeat (40) begin
      send_beat(2'($urandom_range(i2crw_pkg::REQ_TICK, REQ_SPARE)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    set_step(10'd1);
    finish_transaction(5, SDA_RAND);
  endtask

  // hold the result side off while the sender keeps offering beats
  task automatic test_receiver_holdoff();
    set_step(10'd1);
    tx_gaps = 1'b0;
    hold_on = 1'b1;
    send_beat(i2crw_pkg::REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'b0);
    repeat (24) send_beat(i2crw_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 1'($urandom_range(1)));
    hold_on = 1'b0;
    tx_gaps = 1'b1;
    finish_transaction(10, SDA_RAND);
  endtask

  // random transactions under several step lengths
  task automatic test_random_traffic();
    int target;
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_step(10'd1);
        1:       set_step(10'd2);
        2:       set_step(10'd3);
        default: set_step(10'($urandom_range(1, 5)));
      endcase
      // one phase runs without any idling on either side
      tx_gaps = (ph != 1);
      rx_gaps = (ph != 1);
      target = n_beats + 200;
      while (n_beats < target) begin
        if ($urandom_range(99) < 80) begin
          send_beat(2'($urandom_range(i2crw_pkg::REQ_WRITE, i2crw_pkg::REQ_READ)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
          finish_transaction(10, SDA_RAND);
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_beat(2'($urandom_range(i2crw_pkg::REQ_TICK, REQ_SPARE)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
          end
        end
      end
      // sender pause: let every result come back mid-run
      if (ph == 2) drain();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // result-side stall: random, or a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else if (hold_on) begin
      if (hold_cnt < HOLD_LEN) begin
        out_stall <= 1'b1;
        hold_cnt = hold_cnt + 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      hold_cnt = 0;
      out_stall <= rx_gaps && ($urandom_range(99) < 21);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    pins_t want;
    if (!rst && out_valid && !out_stall) begin
      if (done_res === 1'b1) n_done++;
      if (pins_due.size() == 0) begin
        $error("result beat with no expectation waiting");
        n_err++;
      end else begin
        want = pins_due.pop_front();
        if (scl_level !== want.scl) begin
          $error("scl_level expected %0d got %0d", want.scl, scl_level);
          n_err++;
        end
        if (sda_level !== want.sda) begin
          $error("sda_level expected %0d got %0d", want.sda, sda_level);
          n_err++;
        end
        if (sda_drive !== want.drv) begin
          $error("sda_drive expected %0d got %0d", want.drv, sda_drive);
          n_err++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res expected %0d got %0d", want.busy, busy_res);
          n_err++;
        end
        if (done_res !== want.done) begin
          $error("done_res expected %0d got %0d", want.done, done_res);
          n_err++;
        end
        if (read_data !== want.rdata) begin
          $error("read_data expected %0h got %0h", want.rdata, read_data);
          n_err++;
        end
      end
    end
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_step();
    test_write_bytes();
    test_read_bytes();
    test_requests_while_busy();
    test_step_zero();
    test_step_max();
    test_receiver_holdoff();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (pins_due.size() != 0) begin
      $error("%0d expected result beats never arrived", pins_due.size());
      n_err++;
    end
    $display("Ran %0d bus ticks: %0d writes and %0d reads started, %0d completions seen.",
             n_beats, n_writes, n_reads, n_done);
    $display("Step lengths 0 to 1023, random stalls on both sides, one long result hold-off.");
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: i2c_register_access_master_top.f
design/i2crw_pkg.sv
design/i2crw_front.sv
design/i2crw_engine.sv
design/i2c_register_access_master_top.sv
verif/tb.sv
